@@ hdl/calendar_to_epoch_week_core_defines.svh @@
// Assertion macros shared by the calendar-to-epoch RTL.
`ifndef CALENDAR_TO_EPOCH_WEEK_CORE_DEFINES_SVH
`define CALENDAR_TO_EPOCH_WEEK_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define C2EW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define C2EW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/c2ew_pkg.sv @@
// Package: request/result types and constant tables for the calendar-to-epoch core.
`timescale 1ns / 1ps

package c2ew_pkg;

    localparam int EPOCH_YEAR = 1970;
    localparam int YEAR_SPAN  = 130;     // 1970..2099
    localparam int MAX_YEAR   = EPOCH_YEAR + YEAR_SPAN - 1;
    localparam int CENTURY    = 2000;
    localparam int TWO_DIGIT  = 99;
    localparam int FOLD_LIMIT = 1929;
    localparam int FOLD_CYCLE = 28;
    localparam int ADJ_BASE   = 1873;

    typedef struct packed {
        logic [7:0]  hour_in;
        logic [7:0]  minute_in;
        logic [7:0]  second_in;
        logic [7:0]  day_in;
        logic [7:0]  month_in;
        logic [11:0] year_in;
    } t_c2ew_req;

    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic [2:0]  weekday;
        logic [5:0]  week_number;
    } t_c2ew_res;

    // Per-year entry: days from the epoch to January 1, and the week adjusts
    // of the folded year and of the year before it.
    typedef struct packed {
        logic [15:0] days_base;
        logic [3:0]  adj;
        logic [3:0]  padj;
    } t_c2ew_year_ent;

    typedef t_c2ew_year_ent [YEAR_SPAN-1:0] t_c2ew_year_tab;
    typedef logic [11:0][8:0] t_c2ew_month_tab;

    localparam t_c2ew_month_tab DAYS_BEFORE_MONTH = {
        9'd334, 9'd304, 9'd273, 9'd243, 9'd212, 9'd181,
        9'd151, 9'd120, 9'd90,  9'd59,  9'd31,  9'd0
    };

    function automatic logic [3:0] f_fold_adjust(input int yy);
        int a;
        a = yy + (yy >>> 2);
        while (a > 9) begin
            a = a - 7;
        end
        return a[3:0];
    endfunction

    function automatic t_c2ew_year_tab f_build_year_tab();
        t_c2ew_year_tab tab;
        int base;
        int y;
        int fy;
        base = 0;
        for (int i = 0; i < YEAR_SPAN; i++) begin
            y  = EPOCH_YEAR + i;
            fy = y;
            tab[i].days_base = base[15:0];
            if ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) begin
                base = base + 366;
            end else begin
                base = base + 365;
            end
            while (fy >= FOLD_LIMIT) begin
                fy = fy - FOLD_CYCLE;
            end
            tab[i].adj  = f_fold_adjust(fy - ADJ_BASE);
            tab[i].padj = f_fold_adjust(fy - ADJ_BASE - 1);
        end
        return tab;
    endfunction

    localparam t_c2ew_year_tab YEAR_TAB = f_build_year_tab();

endpackage

@@ hdl/calendar_to_epoch_week_core.sv @@
// Top level: civil date/time to Unix seconds, weekday and ISO week number.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// request   in         start & !busy          i_req (t_c2ew_req)
// result    out        o_strobe, one cycle    o_res (t_c2ew_res)
//
// One request per cycle, sustained; each result follows its request through
// the request register, then the result register.
// busy is high only while reset is asserted; reset clears both valid flags.
// The receiver cannot stall, so nothing upstream ever waits on the result.
module calendar_to_epoch_week_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  c2ew_pkg::t_c2ew_req   i_req,
    output logic                  o_strobe,
    output c2ew_pkg::t_c2ew_res   o_res
);
    import c2ew_pkg::*;

    `include "calendar_to_epoch_week_core_defines.svh"

    // Reciprocal constants: floor(x*M >> S) equals x/7 over the ranges used.
    localparam logic [16:0] RECIP7_DAYS  = 17'd74899;   // x < 2^16, shift 19
    localparam int          SHIFT7_DAYS  = 19;
    localparam logic [8:0]  RECIP7_WEEK  = 9'd293;      // x < 2^9, shift 11
    localparam int          SHIFT7_WEEK  = 11;
    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
    localparam logic [5:0]  LAST_WEEK    = 6'd52;
    localparam logic [5:0]  LONG_WEEK    = 6'd53;
    localparam logic [3:0]  ADJ_LONG     = 4'd9;
    localparam logic [3:0]  ADJ_EDGE     = 4'd8;
    localparam logic [2:0]  SUNDAY       = 3'd7;

    logic        w_accept;
    logic        r_req_vld;
    t_c2ew_req   r_req;
    logic        r_res_vld;
    t_c2ew_res   r_res;

    // Clamped fields
    logic [4:0]  w_hr;
    logic [5:0]  w_mi;
    logic [5:0]  w_se;
    logic [4:0]  w_dy;
    logic [3:0]  w_mo;
    logic [7:0]  w_yo;          // year minus the epoch year, 0..129
    logic [1:0]  w_yr_mod4;
    logic        w_leap;

    t_c2ew_year_ent w_yent;
    logic [8:0]  w_doy;         // day of year, 1-based
    logic [15:0] w_days;
    logic [32:0] w_day_prod;
    logic [31:0] w_tod;
    logic [31:0] w_secs;

    logic [15:0] w_wd_x;
    logic [32:0] w_wd_prod;
    logic [13:0] w_wd_q;
    logic [15:0] w_wd_r;
    logic [2:0]  w_wd;

    logic [8:0]  w_wk_x;
    logic [17:0] w_wk_prod;
    logic [5:0]  w_wk;
    logic [5:0]  w_week;

    t_c2ew_res   n_res;

    // Hold requests off only while reset is active.
    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= w_accept;
        end
        if (w_accept) begin
            r_req <= i_req;
        end
    end

    // Clamp every field to its range.
    always_comb begin
        w_hr = (r_req.hour_in   > 8'd23) ? 5'd23 : r_req.hour_in[4:0];
        w_mi = (r_req.minute_in > 8'd59) ? 6'd59 : r_req.minute_in[5:0];
        w_se = (r_req.second_in > 8'd59) ? 6'd59 : r_req.second_in[5:0];

        if (r_req.day_in == 8'd0) begin
            w_dy = 5'd1;
        end else if (r_req.day_in > 8'd31) begin
            w_dy = 5'd31;
        end else begin
            w_dy = r_req.day_in[4:0];
        end

        if (r_req.month_in == 8'd0) begin
            w_mo = 4'd1;
        end else if (r_req.month_in > 8'd12) begin
            w_mo = 4'd12;
        end else begin
            w_mo = r_req.month_in[3:0];
        end

        // Two-digit years land in this century; saturate full years.
        if (r_req.year_in <= 12'(TWO_DIGIT)) begin
            w_yo = 8'(r_req.year_in + 12'(CENTURY - EPOCH_YEAR));
        end else if (r_req.year_in < 12'(EPOCH_YEAR)) begin
            w_yo = 8'd0;
        end else if (r_req.year_in > 12'(MAX_YEAR)) begin
            w_yo = 8'(YEAR_SPAN - 1);
        end else begin
            w_yo = 8'(r_req.year_in - 12'(EPOCH_YEAR));
        end
    end

    // Within 1970..2099 a year is leap exactly when it divides by four.
    assign w_yr_mod4 = w_yo[1:0] + 2'(EPOCH_YEAR % 4);
    assign w_leap    = (w_yr_mod4 == 2'd0);
    assign w_yent    = YEAR_TAB[w_yo];

    always_comb begin
        w_doy = DAYS_BEFORE_MONTH[w_mo - 4'd1] + 9'(w_dy);
        if ((w_mo > 4'd2) && w_leap) begin
            w_doy = w_doy + 9'd1;
        end
    end

    assign w_days     = w_yent.days_base + 16'(w_doy) - 16'd1;
    assign w_day_prod = 33'(w_days) * 33'(SEC_PER_DAY);
    assign w_tod      = 32'(w_hr) * 32'(SEC_PER_HOUR) + 32'(w_mi) * 32'(SEC_PER_MIN)
                      + 32'(w_se);
    assign w_secs     = w_day_prod[31:0] + w_tod;

    // Weekday: the epoch day was a Thursday; fold Monday..Sunday into 1..7.
    assign w_wd_x    = w_days + 16'd4;
    assign w_wd_prod = 33'(w_wd_x) * 33'(RECIP7_DAYS);
    assign w_wd_q    = w_wd_prod[SHIFT7_DAYS +: 14];
    assign w_wd_r    = w_wd_x - 16'(w_wd_q) * 16'd7;
    assign w_wd      = (w_wd_r[2:0] == 3'd0) ? SUNDAY : w_wd_r[2:0];

    // ISO week from the folded-year adjust, then fix the boundary weeks.
    assign w_wk_x    = 9'(w_yent.adj) + w_doy;
    assign w_wk_prod = 18'(w_wk_x) * 18'(RECIP7_WEEK);
    assign w_wk      = w_wk_prod[SHIFT7_WEEK +: 6];

    always_comb begin
        w_week = w_wk;
        if (w_wk == 6'd0) begin
            // Early January belongs to the last week of the prior year.
            if ((w_yent.padj == ADJ_LONG)
                    || ((w_yent.padj == ADJ_EDGE) && (w_yr_mod4 == 2'd1))) begin
                w_week = LONG_WEEK;
            end else begin
                w_week = LAST_WEEK;
            end
        end else if (w_wk > LAST_WEEK) begin
            // Late December either completes week 53 or starts week 1.
            if ((w_yent.adj == ADJ_LONG)
                    || ((w_yent.adj == ADJ_EDGE) && (w_yr_mod4 == 2'd0))) begin
                w_week = LONG_WEEK;
            end else begin
                w_week = 6'd1;
            end
        end
    end

    always_comb begin
        n_res.epoch_seconds = w_secs;
        n_res.weekday       = w_wd;
        n_res.week_number   = w_week;
    end

    // Result register: present each result for exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= r_req_vld;
        end
        if (r_req_vld) begin
            r_res <= n_res;
        end
    end

    assign o_strobe = r_res_vld;
    assign o_res    = r_res;

    `C2EW_ASSERT_NEXT(a_req_loaded, i_clk, i_rst_n, w_accept, r_req_vld,
        "accepted request did not load the request register")
    `C2EW_ASSERT_NEXT(a_res_follows, i_clk, i_rst_n, r_req_vld, o_strobe,
        "registered request produced no result strobe")
    `C2EW_ASSERT_NEXT(a_no_phantom, i_clk, i_rst_n, !r_req_vld, !o_strobe,
        "result strobe without a request")
    `C2EW_ASSERT_SAME(a_weekday_range, i_clk, i_rst_n, o_strobe,
        (o_res.weekday != 3'd0),
        "weekday out of range")
    `C2EW_ASSERT_SAME(a_week_range, i_clk, i_rst_n, o_strobe,
        (o_res.week_number != 6'd0) && (o_res.week_number <= LONG_WEEK),
        "week number out of range")

endmodule
